// File: hdl/qng_pkg.sv
// Shared widths, types and constants of the quaternion normalization gradient.
`default_nettype none
package qng_pkg;

  // Component width and everything that follows from it
  localparam int CB       = 16;
  localparam int LANES    = 4;
  localparam int SQ_W     = 2 * CB + 1;   // sum of four squares
  localparam int LEN_W    = CB + 1;       // integer square root of that sum
  localparam int CUBE_W   = 3 * CB + 1;   // length cubed, also the divisor
  localparam int A_W      = 3 * CB + 1;   // numerator magnitude
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int Q_W      = OUT_W + 1;    // quotient bits kept by the divider
  localparam int FLOOR_W  = 20;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(687);

  typedef logic signed [CB-1:0] comp_t;
  typedef logic signed [OUT_W-1:0] res_t;

  // Signed-magnitude numerator of one lane
  typedef struct packed {
    logic           neg;
    logic [A_W-1:0] mag;
  } num_t;

endpackage
`default_nettype wire

// File: hdl/qng_front.sv
// Front pipeline: squared length and the four numerators, five stages.
`default_nettype none
module qng_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       adv,
  input  wire                       in_valid,
  input  qng_pkg::comp_t            vec  [qng_pkg::LANES],
  input  qng_pkg::comp_t            grad [qng_pkg::LANES],
  output logic                      out_valid,
  output logic [qng_pkg::SQ_W-1:0]  sq,
  output qng_pkg::num_t             num  [qng_pkg::LANES]
);

  localparam int CB    = qng_pkg::CB;
  localparam int LANES = qng_pkg::LANES;
  localparam int SQ_W  = qng_pkg::SQ_W;
  localparam int A_W   = qng_pkg::A_W;
  localparam int DOT_W = 2 * CB + 2;
  localparam int TA_W  = 2 * CB + 1;
  localparam int P_W   = CB + SQ_W;
  localparam int QP_W  = CB + TA_W;

  logic [4:0] v_r;

  // stage 1
  logic [CB-1:0]            vabs1_r [LANES];
  logic [CB-1:0]            gabs1_r [LANES];
  logic                     vneg1_r [LANES];
  logic                     gneg1_r [LANES];
  logic [2*CB-1:0]          sqv1_r  [LANES];
  logic signed [2*CB-1:0]   prod1_r [LANES];
  // stage 2
  logic [CB-1:0]            vabs2_r [LANES];
  logic [CB-1:0]            gabs2_r [LANES];
  logic                     vneg2_r [LANES];
  logic                     gneg2_r [LANES];
  logic [2*CB-1:0]          sqv2_r  [LANES];
  logic signed [2*CB-1:0]   prod2_r [LANES];
  logic [SQ_W-1:0]          sq2_r;
  logic signed [DOT_W-1:0]  dot2_r;
  // stage 3
  logic [CB-1:0]            vabs3_r [LANES];
  logic [CB-1:0]            gabs3_r [LANES];
  logic                     vneg3_r [LANES];
  logic                     gneg3_r [LANES];
  logic [SQ_W-1:0]          s3_r    [LANES];
  logic [TA_W-1:0]          tabs3_r [LANES];
  logic                     tneg3_r [LANES];
  logic [SQ_W-1:0]          sq3_r;
  // stage 4
  logic [A_W-1:0]           p4_r    [LANES];
  logic [A_W-1:0]           q4_r    [LANES];
  logic                     pneg4_r [LANES];
  logic                     qneg4_r [LANES];
  logic [SQ_W-1:0]          sq4_r;
  // stage 5
  qng_pkg::num_t            num5_r  [LANES];
  logic [SQ_W-1:0]          sq5_r;

  // combinational next values
  logic [CB-1:0]            vabs_c  [LANES];
  logic [CB-1:0]            gabs_c  [LANES];
  logic signed [2*CB-1:0]   prod_c  [LANES];
  logic signed [DOT_W-1:0]  t_c     [LANES];
  logic [P_W-1:0]           p_c     [LANES];
  logic [QP_W-1:0]          q_c     [LANES];
  qng_pkg::num_t            num_c   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      vabs_c[i] = vec[i][CB-1]  ? CB'(-vec[i])  : CB'(vec[i]);
      gabs_c[i] = grad[i][CB-1] ? CB'(-grad[i]) : CB'(grad[i]);
      prod_c[i] = (2*CB)'(vec[i]) * (2*CB)'(grad[i]);
      t_c[i]    = dot2_r - DOT_W'(prod2_r[i]);
      p_c[i]    = P_W'(gabs3_r[i]) * P_W'(s3_r[i]);
      q_c[i]    = QP_W'(vabs3_r[i]) * QP_W'(tabs3_r[i]);
      // combine the two signed terms into one magnitude and sign
      if (pneg4_r[i] == qneg4_r[i]) begin
        num_c[i].mag = p4_r[i] + q4_r[i];
        num_c[i].neg = pneg4_r[i];
      end else if (p4_r[i] < q4_r[i]) begin
        num_c[i].mag = q4_r[i] - p4_r[i];
        num_c[i].neg = qneg4_r[i];
      end else begin
        num_c[i].mag = p4_r[i] - q4_r[i];
        num_c[i].neg = pneg4_r[i];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        vabs1_r[i] <= vabs_c[i];
        gabs1_r[i] <= gabs_c[i];
        vneg1_r[i] <= vec[i][CB-1];
        gneg1_r[i] <= grad[i][CB-1];
        sqv1_r[i]  <= (2*CB)'(vabs_c[i]) * (2*CB)'(vabs_c[i]);
        prod1_r[i] <= prod_c[i];

        vabs2_r[i] <= vabs1_r[i];
        gabs2_r[i] <= gabs1_r[i];
        vneg2_r[i] <= vneg1_r[i];
        gneg2_r[i] <= gneg1_r[i];
        sqv2_r[i]  <= sqv1_r[i];
        prod2_r[i] <= prod1_r[i];

        vabs3_r[i] <= vabs2_r[i];
        gabs3_r[i] <= gabs2_r[i];
        vneg3_r[i] <= vneg2_r[i];
        gneg3_r[i] <= gneg2_r[i];
        s3_r[i]    <= sq2_r - SQ_W'(sqv2_r[i]);
        tneg3_r[i] <= t_c[i][DOT_W-1];
        tabs3_r[i] <= t_c[i][DOT_W-1] ? TA_W'(-t_c[i]) : TA_W'(t_c[i]);

        p4_r[i]    <= A_W'(p_c[i]);
        q4_r[i]    <= A_W'(q_c[i]);
        pneg4_r[i] <= gneg3_r[i];
        qneg4_r[i] <= (vneg3_r[i] == tneg3_r[i]);

        num5_r[i]  <= num_c[i];
      end
      sq2_r  <= SQ_W'(sqv1_r[0]) + SQ_W'(sqv1_r[1]) + SQ_W'(sqv1_r[2]) + SQ_W'(sqv1_r[3]);
      dot2_r <= DOT_W'(prod1_r[0]) + DOT_W'(prod1_r[1])
              + DOT_W'(prod1_r[2]) + DOT_W'(prod1_r[3]);
      sq3_r  <= sq2_r;
      sq4_r  <= sq3_r;
      sq5_r  <= sq4_r;
    end
  end

  assign out_valid = v_r[4];
  assign sq        = sq5_r;
  assign num       = num5_r;

endmodule
`default_nettype wire

// File: hdl/qng_root.sv
// Pipelined integer square root, cube and floor clamp of the divisor.
`default_nettype none
module qng_root (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          adv,
  input  wire                          in_valid,
  input  wire [qng_pkg::SQ_W-1:0]      sq,
  input  qng_pkg::num_t                num_in  [qng_pkg::LANES],
  input  wire [qng_pkg::FLOOR_W-1:0]   cube_floor,
  output logic                         out_valid,
  output logic [qng_pkg::CUBE_W-1:0]   divisor,
  output qng_pkg::num_t                num_out [qng_pkg::LANES]
);

  localparam int LANES  = qng_pkg::LANES;
  localparam int SQ_W   = qng_pkg::SQ_W;
  localparam int LEN_W  = qng_pkg::LEN_W;
  localparam int CUBE_W = qng_pkg::CUBE_W;
  localparam int R_W    = SQ_W + 1;
  localparam int C_W    = 3 * LEN_W;
  localparam int DEPTH  = LEN_W + 3;

  logic [DEPTH-1:0]    v_r;
  qng_pkg::num_t       num_r [DEPTH][LANES];
  logic [SQ_W-1:0]     x_r   [LEN_W];
  logic [R_W-1:0]      res_r [LEN_W];
  logic [SQ_W-1:0]     x_nxt   [LEN_W];
  logic [R_W-1:0]      res_nxt [LEN_W];
  logic [LEN_W-1:0]    len_r;
  logic [2*LEN_W-1:0]  len2_r;
  logic [CUBE_W-1:0]   cube_r;
  logic [CUBE_W-1:0]   div_r;
  logic [C_W-1:0]      cube_c;
  logic [CUBE_W-1:0]   floor_c;
  logic [CUBE_W-1:0]   div_nxt;

  // one root digit per stage
  always_comb begin
    logic [R_W-1:0] xi;
    logic [R_W-1:0] ri;
    logic [R_W-1:0] bk;
    logic [R_W-1:0] trial;
    for (int k = 0; k < LEN_W; k++) begin
      xi    = (k == 0) ? R_W'(sq) : R_W'(x_r[k > 0 ? k - 1 : 0]);
      ri    = (k == 0) ? '0 : res_r[k > 0 ? k - 1 : 0];
      bk    = R_W'(1) << (2 * (LEN_W - 1 - k));
      trial = ri + bk;
      if (xi >= trial) begin
        x_nxt[k]   = SQ_W'(xi - trial);
        res_nxt[k] = (ri >> 1) + bk;
      end else begin
        x_nxt[k]   = SQ_W'(xi);
        res_nxt[k] = ri >> 1;
      end
    end
  end

  // clamp the cube to the floor, never divide by zero
  always_comb begin
    cube_c  = C_W'(len2_r) * C_W'(len_r);
    floor_c = CUBE_W'(cube_floor);
    div_nxt = (cube_r < floor_c) ? floor_c : cube_r;
    if (div_nxt == '0) begin
      div_nxt = CUBE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < LEN_W; k++) begin
        x_r[k]   <= x_nxt[k];
        res_r[k] <= res_nxt[k];
      end
      for (int k = 0; k < DEPTH; k++) begin
        for (int i = 0; i < LANES; i++) begin
          num_r[k][i] <= (k == 0) ? num_in[i] : num_r[k > 0 ? k - 1 : 0][i];
        end
      end
      len_r  <= res_r[LEN_W-1][LEN_W-1:0];
      len2_r <= (2*LEN_W)'(res_r[LEN_W-1][LEN_W-1:0])
              * (2*LEN_W)'(res_r[LEN_W-1][LEN_W-1:0]);
      cube_r <= CUBE_W'(cube_c);
      div_r  <= div_nxt;
    end
  end

  assign out_valid = v_r[DEPTH-1];
  assign divisor   = div_r;
  assign num_out   = num_r[DEPTH-1];

endmodule
`default_nettype wire

// File: hdl/qng_div.sv
// Four-lane pipelined restoring divider with saturation and output register.
`default_nettype none
module qng_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          adv,
  input  wire                          in_valid,
  input  wire [qng_pkg::CUBE_W-1:0]    divisor,
  input  qng_pkg::num_t                num [qng_pkg::LANES],
  output logic                         out_valid,
  output qng_pkg::res_t                res [qng_pkg::LANES],
  output logic                         sat
);

  localparam int LANES    = qng_pkg::LANES;
  localparam int CUBE_W   = qng_pkg::CUBE_W;
  localparam int A_W      = qng_pkg::A_W;
  localparam int Q_W      = qng_pkg::Q_W;
  localparam int OUT_W    = qng_pkg::OUT_W;
  localparam int OUT_FRAC = qng_pkg::OUT_FRAC;
  localparam int SPLIT    = Q_W - OUT_FRAC;
  localparam int HI_W     = A_W - SPLIT;
  localparam int CMP_W    = (HI_W > CUBE_W) ? HI_W : CUBE_W;

  // prep stage
  logic                vp_r;
  logic [CUBE_W-1:0]   dp_r;
  logic [CUBE_W-1:0]   remp_r [LANES];
  logic [Q_W-1:0]      lowp_r [LANES];
  logic                ovfp_r [LANES];
  logic                negp_r [LANES];
  // quotient stages
  logic [Q_W-1:0]      v_r;
  logic [CUBE_W-1:0]   d_r    [Q_W];
  logic [CUBE_W-1:0]   rem_r  [Q_W][LANES];
  logic [Q_W-1:0]      low_r  [Q_W][LANES];
  logic [Q_W-1:0]      quo_r  [Q_W][LANES];
  logic                ovf_r  [Q_W][LANES];
  logic                neg_r  [Q_W][LANES];
  logic [CUBE_W-1:0]   rem_nxt [Q_W][LANES];
  logic [Q_W-1:0]      quo_nxt [Q_W][LANES];
  // output register
  logic                vo_r;
  qng_pkg::res_t       res_r  [LANES];
  logic                sat_r;
  qng_pkg::res_t       res_nxt [LANES];
  logic                sat_nxt;

  // one quotient bit per stage
  always_comb begin
    logic [CUBE_W-1:0] rin;
    logic [Q_W-1:0]    lin;
    logic [Q_W-1:0]    qin;
    logic [CUBE_W-1:0] din;
    logic [CUBE_W:0]   trial;
    for (int k = 0; k < Q_W; k++) begin
      for (int i = 0; i < LANES; i++) begin
        rin   = (k == 0) ? remp_r[i] : rem_r[k > 0 ? k - 1 : 0][i];
        lin   = (k == 0) ? lowp_r[i] : low_r[k > 0 ? k - 1 : 0][i];
        qin   = (k == 0) ? '0 : quo_r[k > 0 ? k - 1 : 0][i];
        din   = (k == 0) ? dp_r : d_r[k > 0 ? k - 1 : 0];
        trial = {rin, lin[Q_W-1]};
        if (trial >= {1'b0, din}) begin
          rem_nxt[k][i] = CUBE_W'(trial - {1'b0, din});
          quo_nxt[k][i] = {qin[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][i] = CUBE_W'(trial);
          quo_nxt[k][i] = {qin[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // clamp and apply the sign
  always_comb begin
    logic [Q_W-1:0] limit;
    logic [Q_W-1:0] mag;
    logic           clamp;
    sat_nxt = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      limit = neg_r[Q_W-1][i] ? (Q_W'(1) << (OUT_W - 1)) : ((Q_W'(1) << (OUT_W - 1)) - 1'b1);
      clamp = ovf_r[Q_W-1][i] || (quo_r[Q_W-1][i] > limit);
      mag   = clamp ? limit : quo_r[Q_W-1][i];
      res_nxt[i] = neg_r[Q_W-1][i] ? OUT_W'(-mag) : OUT_W'(mag);
      sat_nxt = sat_nxt | clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (adv) begin
      vp_r <= in_valid;
      v_r  <= {v_r[Q_W-2:0], vp_r};
      vo_r <= v_r[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // split the shifted numerator: upper part seeds the remainder
      dp_r <= divisor;
      for (int i = 0; i < LANES; i++) begin
        ovfp_r[i] <= CMP_W'(num[i].mag[A_W-1:SPLIT]) >= CMP_W'(divisor);
        remp_r[i] <= CUBE_W'(num[i].mag[A_W-1:SPLIT]);
        lowp_r[i] <= {num[i].mag[SPLIT-1:0], {OUT_FRAC{1'b0}}};
        negp_r[i] <= num[i].neg;
      end
      for (int k = 0; k < Q_W; k++) begin
        d_r[k] <= (k == 0) ? dp_r : d_r[k > 0 ? k - 1 : 0];
        for (int i = 0; i < LANES; i++) begin
          rem_r[k][i] <= rem_nxt[k][i];
          quo_r[k][i] <= quo_nxt[k][i];
          low_r[k][i] <= (k == 0) ? (lowp_r[i] << 1) : (low_r[k > 0 ? k - 1 : 0][i] << 1);
          ovf_r[k][i] <= (k == 0) ? ovfp_r[i] : ovf_r[k > 0 ? k - 1 : 0][i];
          neg_r[k][i] <= (k == 0) ? negp_r[i] : neg_r[k > 0 ? k - 1 : 0][i];
        end
      end
      for (int i = 0; i < LANES; i++) begin
        res_r[i] <= res_nxt[i];
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid = vo_r;
  assign res       = res_r;
  assign sat       = sat_r;

endmodule
`default_nettype wire

// File: hdl/quaternion_normalize_gradient.sv
// Top level of the quaternion normalization gradient pipeline.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_vec_w..z, in_grad_w..z
//   out_     output     out_valid / out_ready out_w..z, out_saturated
//   cfg_     input      cfg_valid / cfg_ready cfg_cube_floor
//
// One item enters per cycle while the output is not stalled; there are 5 front
// stages, 17 root stages, 3 cube and floor stages, 35 divider stages including
// the output register. The 33-stage restoring divider sets the depth.
// Synchronous active-low reset clears all valid bits and loads the floor.
// A stalled output freezes the whole pipeline, so no item is lost or repeated.
`default_nettype none
module quaternion_normalize_gradient (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire signed [qng_pkg::CB-1:0]    in_vec_w,
  input  wire signed [qng_pkg::CB-1:0]    in_vec_x,
  input  wire signed [qng_pkg::CB-1:0]    in_vec_y,
  input  wire signed [qng_pkg::CB-1:0]    in_vec_z,
  input  wire signed [qng_pkg::CB-1:0]    in_grad_w,
  input  wire signed [qng_pkg::CB-1:0]    in_grad_x,
  input  wire signed [qng_pkg::CB-1:0]    in_grad_y,
  input  wire signed [qng_pkg::CB-1:0]    in_grad_z,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic signed [qng_pkg::OUT_W-1:0] out_w,
  output logic signed [qng_pkg::OUT_W-1:0] out_x,
  output logic signed [qng_pkg::OUT_W-1:0] out_y,
  output logic signed [qng_pkg::OUT_W-1:0] out_z,
  output logic                            out_saturated,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [qng_pkg::FLOOR_W-1:0]      cfg_cube_floor
);

  localparam int LANES = qng_pkg::LANES;

  logic                          adv;
  logic [qng_pkg::FLOOR_W-1:0]   cube_floor_r;
  qng_pkg::comp_t                vec  [LANES];
  qng_pkg::comp_t                grad [LANES];
  logic                          f_valid;
  logic [qng_pkg::SQ_W-1:0]      f_sq;
  qng_pkg::num_t                 f_num [LANES];
  logic                          r_valid;
  logic [qng_pkg::CUBE_W-1:0]    r_div;
  qng_pkg::num_t                 r_num [LANES];
  qng_pkg::res_t                 d_res [LANES];

  // advance whenever the output register is empty or being taken
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // hold the floor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_floor_r <= qng_pkg::FLOOR_RESET;
    end else if (cfg_valid) begin
      cube_floor_r <= cfg_cube_floor;
    end
  end

  assign vec[0]  = in_vec_w;
  assign vec[1]  = in_vec_x;
  assign vec[2]  = in_vec_y;
  assign vec[3]  = in_vec_z;
  assign grad[0] = in_grad_w;
  assign grad[1] = in_grad_x;
  assign grad[2] = in_grad_y;
  assign grad[3] = in_grad_z;

  qng_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .vec       (vec),
    .grad      (grad),
    .out_valid (f_valid),
    .sq        (f_sq),
    .num       (f_num)
  );

  qng_root u_root (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (f_valid),
    .sq         (f_sq),
    .num_in     (f_num),
    .cube_floor (cube_floor_r),
    .out_valid  (r_valid),
    .divisor    (r_div),
    .num_out    (r_num)
  );

  qng_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (r_valid),
    .divisor   (r_div),
    .num       (r_num),
    .out_valid (out_valid),
    .res       (d_res),
    .sat       (out_saturated)
  );

  assign out_w = d_res[0];
  assign out_x = d_res[1];
  assign out_y = d_res[2];
  assign out_z = d_res[3];

endmodule
`default_nettype wire

// File: hdl/qng_checker.sv
// Port-level checks of the quaternion normalization gradient, bound to the top.
`default_nettype none
module qng_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_w,
  input wire [31:0] out_x,
  input wire [31:0] out_y,
  input wire [31:0] out_z,
  input wire        out_saturated
);

  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;

  logic [6:0] pending_r;

  // count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 7'(in_valid && in_ready) - 7'(out_valid && out_ready);
    end
  end

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
      && $stable(out_y) && $stable(out_z) && $stable(out_saturated))
    else $error("stalled result changed");

  // never deliver an item that was not accepted
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 7'd0)
    else $error("result without pending item");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // a clamp shows a limit value in some component
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_w == MAX_POS || out_w == MAX_NEG
      || out_x == MAX_POS || out_x == MAX_NEG || out_y == MAX_POS
      || out_y == MAX_NEG || out_z == MAX_POS || out_z == MAX_NEG)
    else $error("saturated flag without limit value");

endmodule

bind quaternion_normalize_gradient qng_checker u_qng_checker (.*);
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the quaternion normalization gradient pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  typedef struct {
    logic signed [qng_pkg::OUT_W-1:0] w, x, y, z;
    logic                             sat;
  } grad_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  qng_pkg::comp_t in_vec_w = '0, in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  qng_pkg::comp_t in_grad_w = '0, in_grad_x = '0, in_grad_y = '0, in_grad_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qng_pkg::res_t out_w, out_x, out_y, out_z;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qng_pkg::FLOOR_W-1:0] cfg_cube_floor = '0;

  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 800000;

  grad_res_t expected_q[$];
  logic [qng_pkg::FLOOR_W-1:0] floor_shadow = qng_pkg::FLOOR_RESET;
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int rx_gap = 0;

  quaternion_normalize_gradient uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vec_w(in_vec_w), .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_grad_w(in_grad_w), .in_grad_x(in_grad_x), .in_grad_y(in_grad_y),
    .in_grad_z(in_grad_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_cube_floor(cfg_cube_floor)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_normalize_gradient regression: fail");
      $finish;
    end
  end

  // Integer square root, rounded down
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Compute the normalization gradient of one quaternion
  function automatic grad_res_t norm_gradient(qng_pkg::comp_t v[4], qng_pkg::comp_t g[4],
                                              logic [qng_pkg::FLOOR_W-1:0] flr);
    grad_res_t res;
    logic signed [127:0] sq, dot, s, t, num, quo, cube;
    longint unsigned len;
    logic signed [qng_pkg::OUT_W-1:0] lane [4];
    logic sat;
    sq = 0;
    dot = 0;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sq += 128'(v[i]) * 128'(v[i]);
      dot += 128'(v[i]) * 128'(g[i]);
    end
    len = root_floor(64'(sq));
    cube = 128'(len) * 128'(len) * 128'(len);
    if (cube < 128'(flr)) cube = 128'(flr);
    if (cube == 0) cube = 1;
    for (int i = 0; i < 4; i++) begin
      s = sq - 128'(v[i]) * 128'(v[i]);
      t = dot - 128'(v[i]) * 128'(g[i]);
      num = 128'(g[i]) * s - 128'(v[i]) * t;
      // signed division truncates toward zero
      quo = (num <<< qng_pkg::OUT_FRAC) / cube;
      if (quo > 128'sd2147483647) begin
        quo = 128'sd2147483647;
        sat = 1'b1;
      end else if (quo < -128'sd2147483648) begin
        quo = -128'sd2147483648;
        sat = 1'b1;
      end
      lane[i] = quo[qng_pkg::OUT_W-1:0];
    end
    res.w = lane[0];
    res.x = lane[1];
    res.y = lane[2];
    res.z = lane[3];
    res.sat = sat;
    return res;
  endfunction

  // Random idle length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item and queue its expected result; valid stays up for the next item
  task automatic send_item(qng_pkg::comp_t v[4], qng_pkg::comp_t g[4], bit idle);
    int gap;
    gap = idle ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_vec_w <= v[0]; in_vec_x <= v[1]; in_vec_y <= v[2]; in_vec_z <= v[3];
    in_grad_w <= g[0]; in_grad_x <= g[1]; in_grad_y <= g[2]; in_grad_z <= g[3];
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(norm_gradient(v, g, floor_shadow));
    @(negedge clk);
  endtask

  // Stop offering items and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_floor(logic [qng_pkg::FLOOR_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_cube_floor <= value;
    do @(posedge clk); while (!cfg_ready);
    floor_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic qng_pkg::comp_t rand_comp(int mode);
    case (mode)
      0: return qng_pkg::comp_t'($urandom());
      1: return qng_pkg::comp_t'($urandom_range(0, 15) - 8);
      2: return ($urandom_range(0, 1)) ? qng_pkg::comp_t'(16'h7fff) : qng_pkg::comp_t'(16'h8000);
      default: return qng_pkg::comp_t'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  task automatic send_random(int count, bit idle);
    qng_pkg::comp_t v[4], g[4];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        v[i] = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode);
        g[i] = rand_comp($urandom_range(0, 3));
      end
      if ($urandom_range(0, 15) == 0) v = '{default: 0};
      send_item(v, g, idle);
    end
  endtask

  // Directed extremes, zero vector and saturation
  task automatic test_directed();
    qng_pkg::comp_t v[4], g[4];
    qng_pkg::comp_t corner[6] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
                                  16'sh1000};
    v = '{default: 0}; g = '{default: 0};
    send_item(v, g, 1'b0);
    g = '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff};
    send_item(v, g, 1'b0);
    for (int k = 0; k < 6; k++) begin
      v = '{default: corner[k]};
      g = '{corner[(k + 1) % 6], corner[(k + 2) % 6], corner[(k + 3) % 6], corner[k]};
      send_item(v, g, 1'b0);
    end
    v = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000};
    g = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_item(v, g, 1'b0);
    v = '{16'sh8000, 16'sh0001, 16'sh0000, 16'sh0000};
    g = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff};
    send_item(v, g, 1'b0);
    v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    g = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    send_item(v, g, 1'b0);
  endtask

  // Zero floor with a zero vector must divide by one; random items run at four floors
  task automatic test_floor_settings();
    qng_pkg::comp_t v[4], g[4];
    write_floor('0);
    v = '{default: 0};
    g = '{16'sh1234, 16'sh8000, 16'sh7fff, 16'shffff};
    send_item(v, g, 1'b0);
    send_random(150, 1'b1);
    write_floor({qng_pkg::FLOOR_W{1'b1}});
    send_random(150, 1'b1);
    write_floor(20'd1);
    send_random(150, 1'b1);
    write_floor(20'h5a5a5);
    send_random(150, 1'b1);
    write_floor(qng_pkg::FLOOR_RESET);
  endtask

  // Stall the receiver for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_cycles = 200;
    hold_off = 1'b1;
    send_random(120, 1'b0);
    in_valid <= 1'b0;
    wait (hold_cycles == 0);
    hold_off = 1'b0;
    drain();
  endtask

  task automatic test_random();
    send_random(500, 1'b1);
    send_random(200, 1'b0);
    send_random(250, 1'b1);
  endtask

  // Receiver: random ready with short and occasional long idles, plus a counted hold-off
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off && hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (r < 2) begin
      out_ready <= 1'b0;
      rx_gap <= $urandom_range(10, 40);
    end else if (r < 30) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    grad_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: w=%0d x=%0d y=%0d z=%0d", out_w, out_x, out_y, out_z);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_w !== exp_res.w) begin
          $error("out_w: expected %0d, actual %0d", exp_res.w, out_w);
          errors++;
        end
        if (out_x !== exp_res.x) begin
          $error("out_x: expected %0d, actual %0d", exp_res.x, out_x);
          errors++;
        end
        if (out_y !== exp_res.y) begin
          $error("out_y: expected %0d, actual %0d", exp_res.y, out_y);
          errors++;
        end
        if (out_z !== exp_res.z) begin
          $error("out_z: expected %0d, actual %0d", exp_res.z, out_z);
          errors++;
        end
        if (out_saturated !== exp_res.sat) begin
          $error("out_saturated: expected %0b, actual %0b", exp_res.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_floor_settings();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("quaternion_normalize_gradient regression: pass");
    end else begin
      $display("quaternion_normalize_gradient regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/qng_pkg.sv
hdl/qng_front.sv
hdl/qng_root.sv
hdl/qng_div.sv
hdl/quaternion_normalize_gradient.sv
hdl/qng_checker.sv
dv/tb_top.sv
